[hw/rtl/ratamr_pkg.sv]
// Shared types and codes for the rational add/multiply/reduce block.
// Used by ratamr_ctrl, ratamr_dp and rational_add_mul_reduce_top.
`default_nettype none

package ratamr_pkg;

  // Result word width
  localparam int RES_W = 32;

  // Operation codes carried in the input tuser
  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_MUL = 2'd1;
  localparam logic [1:0] OP_INC = 2'd2;
  localparam logic [1:0] OP_CMP = 2'd3;

  // Multiplier operand pairs
  localparam logic [1:0] MS_AN_BD = 2'd0;
  localparam logic [1:0] MS_BN_AD = 2'd1;
  localparam logic [1:0] MS_AD_BD = 2'd2;
  localparam logic [1:0] MS_AN_BN = 2'd3;

  // Numerator register actions
  localparam logic [1:0] NO_HOLD = 2'd0;
  localparam logic [1:0] NO_PROD = 2'd1;
  localparam logic [1:0] NO_ACC  = 2'd2;
  localparam logic [1:0] NO_INC  = 2'd3;

  // Output register sources
  localparam logic [1:0] OUT_RAW = 2'd0;
  localparam logic [1:0] OUT_QUO = 2'd1;
  localparam logic [1:0] OUT_CMP = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic       capture;
    logic [1:0] mul_sel;
    logic [1:0] num_op;
    logic       den_prod;
    logic       den_inc;
    logic       gcd_init;
    logic       gcd_step;
    logic       div_init;
    logic       div_step;
    logic       out_load;
    logic [1:0] out_sel;
  } ratamr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       reducible;
    logic       gcd_done;
    logic       g_one;
  } ratamr_sts_t;

endpackage

`default_nettype wire

[hw/rtl/ratamr_ctrl.sv]
// Sequencer for the rational block: steps add/mul, increment, gcd and divide.
// Depends on ratamr_pkg for command/status structs and codes.
`default_nettype none

module ratamr_ctrl
  import ratamr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic [1:0]  in_op,
  output logic        in_tready,
  input  logic        out_tready,
  output logic        out_tvalid,
  output ratamr_cmd_t cmd,
  input  ratamr_sts_t sts
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MUL0  = 4'd1;
  localparam logic [3:0] S_MUL1  = 4'd2;
  localparam logic [3:0] S_MUL2  = 4'd3;
  localparam logic [3:0] S_MUL3  = 4'd4;
  localparam logic [3:0] S_INC   = 4'd5;
  localparam logic [3:0] S_CHECK = 4'd6;
  localparam logic [3:0] S_GCD   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam int          CNT_W   = $clog2(RES_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RES_W - 1);

  logic [3:0]       state_r, state_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_free   = !out_valid_r || out_tready;

  // Next state and command decode
  always_comb begin
    state_nxt    = state_r;
    mode_nxt     = mode_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.mul_sel  = MS_AN_BD;
    cmd.num_op   = NO_HOLD;
    cmd.out_sel  = mode_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          unique case (in_op) inside
            OP_ADD, OP_MUL: state_nxt = S_MUL0;
            OP_INC:         state_nxt = S_INC;
            default: begin
              mode_nxt  = OUT_CMP;
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_MUL0: begin
        cmd.mul_sel = (sts.op == OP_ADD) ? MS_AN_BD : MS_AN_BN;
        state_nxt   = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul_sel = (sts.op == OP_ADD) ? MS_BN_AD : MS_AD_BD;
        cmd.num_op  = NO_PROD;
        state_nxt   = S_MUL2;
      end
      S_MUL2: begin
        if (sts.op == OP_ADD) begin
          cmd.mul_sel = MS_AD_BD;
          cmd.num_op  = NO_ACC;
          state_nxt   = S_MUL3;
        end else begin
          cmd.den_prod = 1'b1;
          state_nxt    = S_CHECK;
        end
      end
      S_MUL3: begin
        cmd.den_prod = 1'b1;
        state_nxt    = S_CHECK;
      end
      S_INC: begin
        cmd.num_op  = NO_INC;
        cmd.den_inc = 1'b1;
        state_nxt   = S_CHECK;
      end
      S_CHECK: begin
        if (sts.reducible) begin
          cmd.gcd_init = 1'b1;
          state_nxt    = S_GCD;
        end else begin
          mode_nxt  = OUT_RAW;
          state_nxt = S_OUT;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          if (sts.g_one) begin
            mode_nxt  = OUT_RAW;
            state_nxt = S_OUT;
          end else begin
            cmd.div_init = 1'b1;
            cnt_nxt      = '0;
            state_nxt    = S_DIV;
          end
        end else begin
          cmd.gcd_step = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          mode_nxt  = OUT_QUO;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Output valid: set on load, drop when taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mode_r      <= OUT_RAW;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input taken again right after an accept");

  a_gcd_on_positive: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.gcd_step |-> sts.reducible)
    else $error("gcd stepping on a value that is not positive");

  a_valid_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_OUT))
    else $error("result valid raised outside the output state");
`endif

endmodule

`default_nettype wire

[hw/rtl/ratamr_dp.sv]
// Datapath for the rational block: shared multiplier, binary gcd, two-lane
// restoring divider and the output register. Depends on ratamr_pkg.
`default_nettype none

module ratamr_dp
  import ratamr_pkg::*;
#(
  parameter int IN_WIDTH = 16
) (
  input  logic                       clk,
  input  logic [1:0]                 in_op,
  input  logic signed [IN_WIDTH-1:0] in_a_num,
  input  logic signed [IN_WIDTH-1:0] in_a_den,
  input  logic signed [IN_WIDTH-1:0] in_b_num,
  input  logic signed [IN_WIDTH-1:0] in_b_den,
  input  ratamr_cmd_t                cmd,
  output ratamr_sts_t                sts,
  output logic signed [RES_W-1:0]    res_num,
  output logic signed [RES_W-1:0]    res_den,
  output logic                       equal
);

  localparam int K_W = $clog2(RES_W);

  // One restoring-division step: returns {remainder, quotient}
  function automatic logic [2*RES_W-1:0] div_lane(input logic [RES_W-1:0] rem,
                                                  input logic [RES_W-1:0] quo,
                                                  input logic [RES_W-1:0] dvs);
    logic [RES_W:0] trial;
    logic [RES_W:0] diff;
    logic           q_bit;
    trial = {rem, quo[RES_W-1]};
    diff  = trial - {1'b0, dvs};
    q_bit = (trial >= {1'b0, dvs});
    return {(q_bit ? diff[RES_W-1:0] : trial[RES_W-1:0]), quo[RES_W-2:0], q_bit};
  endfunction

  // Sign-extend an input field to the result width
  function automatic logic [RES_W-1:0] ext(input logic [IN_WIDTH-1:0] v);
    return {{(RES_W-IN_WIDTH){v[IN_WIDTH-1]}}, v};
  endfunction

  logic [1:0]          op_r;
  logic [IN_WIDTH-1:0] an_r, ad_r, bn_r, bd_r;
  logic [RES_W-1:0]    prod_r, prod_nxt;
  logic [RES_W-1:0]    num_r, num_nxt;
  logic [RES_W-1:0]    den_r, den_nxt;
  logic [RES_W-1:0]    x_r, x_nxt, y_r, y_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [RES_W-1:0]    g_r;
  logic [RES_W-1:0]    qn_r, qn_nxt, qd_r, qd_nxt;
  logic [RES_W-1:0]    rn_r, rn_nxt, rd_r, rd_nxt;
  logic [RES_W-1:0]    res_num_r, res_den_r;
  logic                equal_r;
  logic [RES_W-1:0]    mul_a, mul_b;
  logic [RES_W-1:0]    g_val;
  logic [2*RES_W-1:0]  lane_n, lane_d;

  // Capture the item
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r <= in_op;
      an_r <= in_a_num;
      ad_r <= in_a_den;
      bn_r <= in_b_num;
      bd_r <= in_b_den;
    end
  end

  // Shared multiplier, low word only
  always_comb begin
    case (cmd.mul_sel)
      MS_AN_BD: begin mul_a = ext(an_r); mul_b = ext(bd_r); end
      MS_BN_AD: begin mul_a = ext(bn_r); mul_b = ext(ad_r); end
      MS_AD_BD: begin mul_a = ext(ad_r); mul_b = ext(bd_r); end
      default:  begin mul_a = ext(an_r); mul_b = ext(bn_r); end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // Unreduced numerator and denominator
  always_comb begin
    case (cmd.num_op)
      NO_PROD: num_nxt = prod_r;
      NO_ACC:  num_nxt = num_r + prod_r;
      NO_INC:  num_nxt = ext(an_r) + ext(ad_r);
      default: num_nxt = num_r;
    endcase
    if (cmd.den_prod) begin
      den_nxt = prod_r;
    end else if (cmd.den_inc) begin
      den_nxt = ext(ad_r);
    end else begin
      den_nxt = den_r;
    end
  end

  // Binary gcd: strip common twos, halve evens, subtract odds
  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    k_nxt = k_r;
    if (cmd.gcd_init) begin
      x_nxt = num_r;
      y_nxt = den_r;
      k_nxt = '0;
    end else if (cmd.gcd_step) begin
      if (!x_r[0] && !y_r[0]) begin
        x_nxt = x_r >> 1;
        y_nxt = y_r >> 1;
        k_nxt = k_r + 1'b1;
      end else if (!x_r[0]) begin
        x_nxt = x_r >> 1;
      end else if (!y_r[0]) begin
        y_nxt = y_r >> 1;
      end else if (x_r > y_r) begin
        x_nxt = (x_r - y_r) >> 1;
      end else begin
        y_nxt = (y_r - x_r) >> 1;
      end
    end
  end

  assign g_val = x_r << k_r;

  // Divide numerator and denominator by the gcd, one bit per cycle
  assign lane_n = div_lane(rn_r, qn_r, g_r);
  assign lane_d = div_lane(rd_r, qd_r, g_r);

  always_comb begin
    qn_nxt = qn_r;
    qd_nxt = qd_r;
    rn_nxt = rn_r;
    rd_nxt = rd_r;
    if (cmd.div_init) begin
      qn_nxt = num_r;
      qd_nxt = den_r;
      rn_nxt = '0;
      rd_nxt = '0;
    end else if (cmd.div_step) begin
      rn_nxt = lane_n[2*RES_W-1:RES_W];
      qn_nxt = lane_n[RES_W-1:0];
      rd_nxt = lane_d[2*RES_W-1:RES_W];
      qd_nxt = lane_d[RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= prod_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    x_r    <= x_nxt;
    y_r    <= y_nxt;
    k_r    <= k_nxt;
    qn_r   <= qn_nxt;
    qd_r   <= qd_nxt;
    rn_r   <= rn_nxt;
    rd_r   <= rd_nxt;
    if (cmd.div_init) begin
      g_r <= g_val;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_sel)
        OUT_QUO: begin
          res_num_r <= qn_r;
          res_den_r <= qd_r;
          equal_r   <= 1'b0;
        end
        OUT_CMP: begin
          res_num_r <= '0;
          res_den_r <= '0;
          equal_r   <= (an_r == bn_r) && (ad_r == bd_r);
        end
        default: begin
          res_num_r <= num_r;
          res_den_r <= den_r;
          equal_r   <= 1'b0;
        end
      endcase
    end
  end

  assign res_num = res_num_r;
  assign res_den = res_den_r;
  assign equal   = equal_r;

  // Status to the controller
  assign sts.op        = op_r;
  assign sts.reducible = !num_r[RES_W-1] && (num_r != '0) &&
                         !den_r[RES_W-1] && (den_r != '0);
  assign sts.gcd_done  = (x_r == y_r);
  assign sts.g_one     = (x_r == RES_W'(1)) && (k_r == '0);

endmodule

`default_nettype wire

[hw/rtl/rational_add_mul_reduce_top.sv]
// Rational add / multiply / increment / compare with gcd reduction.
// Compare goes straight to the output. Other results with both parts positive
// are reduced: binary gcd loop one step per cycle, then a restoring divide
// of both words at once.
// One item at a time: in_tready returns the cycle after the result is loaded,
// and the result waits in the output state while an earlier one is unread.
// Synchronous active-low reset clears the sequencer and the output valid.
`default_nettype none

module rational_add_mul_reduce_top
  import ratamr_pkg::*;
#(
  parameter int IN_WIDTH = 16
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // a_num, a_den, b_num, b_den from bit 0 up, zero padded to whole bytes
  input  logic [((4*IN_WIDTH+7)/8)*8-1:0] in_tdata,
  // op
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // res_num, res_den from bit 0 up
  output logic [2*RES_W-1:0] out_tdata,
  // equal
  output logic out_tuser
);

  ratamr_cmd_t             cmd;
  ratamr_sts_t             sts;
  logic signed [RES_W-1:0] res_num, res_den;

  ratamr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_tready  (in_tready),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .cmd        (cmd),
    .sts        (sts)
  );

  ratamr_dp #(
    .IN_WIDTH (IN_WIDTH)
  ) u_dp (
    .clk      (clk),
    .in_op    (in_tuser),
    .in_a_num (in_tdata[IN_WIDTH-1:0]),
    .in_a_den (in_tdata[2*IN_WIDTH-1:IN_WIDTH]),
    .in_b_num (in_tdata[3*IN_WIDTH-1:2*IN_WIDTH]),
    .in_b_den (in_tdata[4*IN_WIDTH-1:3*IN_WIDTH]),
    .cmd      (cmd),
    .sts      (sts),
    .res_num  (res_num),
    .res_den  (res_den),
    .equal    (out_tuser)
  );

  assign out_tdata = {res_den, res_num};

endmodule

`default_nettype wire

[tb/sv/tb_rational_add_mul_reduce_top.sv]
// Self-checking testbench for rational_add_mul_reduce_top: fraction add,
// multiply, increment and compare with gcd reduction over valid/ready streams.
// Depends on ratamr_pkg (op codes, result width) and the top-level RTL.
module tb_rational_add_mul_reduce_top;
  import ratamr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IN_W        = 16;
  localparam int LIMIT_CYCLES = 1000000;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 450;
  localparam int N_DIR       = 23;

  // Expected result of one item
  typedef struct packed {
    logic [RES_W-1:0] num;
    logic [RES_W-1:0] den;
    logic             eq;
  } rat_res_t;

  // One directed row; hand-written result used only when has_want is set
  typedef struct packed {
    logic [1:0]      op;
    logic [IN_W-1:0] an;
    logic [IN_W-1:0] ad;
    logic [IN_W-1:0] bn;
    logic [IN_W-1:0] bd;
    logic            has_want;
    logic [RES_W-1:0] w_num;
    logic [RES_W-1:0] w_den;
    logic            w_eq;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic in_tvalid;
  logic in_tready;
  // a_num, a_den, b_num, b_den from bit 0 up
  logic [4*IN_W-1:0] in_tdata;
  // op
  logic [1:0] in_tuser;
  logic out_tvalid;
  logic out_tready;
  // res_num, res_den from bit 0 up
  logic [2*RES_W-1:0] out_tdata;
  // equal
  logic out_tuser;

  rat_res_t ratio_q[$];
  int mismatch_cnt = 0;
  int cycle_cnt = 0;
  int src_idle_pct = 20;
  int snk_idle_pct = 59;
  bit stall_req = 0;

  dir_row_t dir_rows [N_DIR] = '{
    // compare: exact match, one field off, most negative codes; zeros come last
    '{OP_CMP, 16'h0005, 16'h0007, 16'h0005, 16'h0007, 1'b1, 32'h0, 32'h0, 1'b1},
    '{OP_CMP, 16'h0005, 16'h0007, 16'h0005, 16'h0008, 1'b1, 32'h0, 32'h0, 1'b0},
    '{OP_CMP, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1, 32'h0, 32'h0, 1'b1},
    '{OP_CMP, 16'h7FFF, 16'h8001, 16'h7FFF, 16'h8000, 1'b1, 32'h0, 32'h0, 1'b0},
    // add: reduce to one, zero denominators, max positive, wrap past 32 bits
    '{OP_ADD, 16'h0001, 16'h0002, 16'h0001, 16'h0002, 1'b1, 32'h1, 32'h1, 1'b0},
    '{OP_ADD, 16'h0003, 16'h0000, 16'h0005, 16'h0000, 1'b1, 32'h0, 32'h0, 1'b0},
    '{OP_ADD, 16'h7FFF, 16'h0001, 16'h7FFF, 16'h0001, 1'b1, 32'h0000FFFE, 32'h1, 1'b0},
    '{OP_ADD, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1,
      32'h80000000, 32'h40000000, 1'b0},
    '{OP_ADD, 16'h7FFF, 16'h8001, 16'h8001, 16'h7FFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_ADD, 16'hFFFF, 16'h0003, 16'h0001, 16'h0003, 1'b1, 32'h0, 32'h9, 1'b0},
    // multiply: zero numerator, extremes, negative left unreduced
    '{OP_MUL, 16'h0000, 16'h0005, 16'h0003, 16'h0007, 1'b1, 32'h0, 32'd35, 1'b0},
    '{OP_MUL, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1, 32'h1, 32'h1, 1'b0},
    '{OP_MUL, 16'h8000, 16'h0001, 16'h8000, 16'h0001, 1'b1, 32'h40000000, 32'h1, 1'b0},
    '{OP_MUL, 16'hFFFA, 16'h0004, 16'h0001, 16'h0001, 1'b1, 32'hFFFFFFFA, 32'h4, 1'b0},
    '{OP_MUL, 16'h8000, 16'h8000, 16'h7FFF, 16'h8001, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_MUL, 16'h000C, 16'h0012, 16'h0005, 16'h000A, 1'b0, 32'h0, 32'h0, 1'b0},
    // increment: second fraction ignored, zero and negative denominators
    '{OP_INC, 16'h0003, 16'h0004, 16'hAAAA, 16'h5555, 1'b1, 32'h7, 32'h4, 1'b0},
    '{OP_INC, 16'h7FFF, 16'h7FFF, 16'h0000, 16'h0000, 1'b1, 32'h2, 32'h1, 1'b0},
    '{OP_INC, 16'h8000, 16'h8000, 16'hFFFF, 16'hFFFF, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_INC, 16'h0005, 16'h0000, 16'h0001, 16'h0001, 1'b1, 32'h5, 32'h0, 1'b0},
    '{OP_INC, 16'h7FFF, 16'hFFFF, 16'h1234, 16'h4321, 1'b1,
      32'h00007FFE, 32'hFFFFFFFF, 1'b0},
    '{OP_ADD, 16'h0002, 16'h0003, 16'hFFFF, 16'h0006, 1'b0, 32'h0, 32'h0, 1'b0},
    '{OP_CMP, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b1, 32'h0, 32'h0, 1'b1}
  };

  rational_add_mul_reduce_top #(
    .IN_WIDTH(IN_W)
  ) u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // Free-running clock, 4 ns period
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Compute the expected fraction for one item
  function automatic rat_res_t predict_ratio(input logic [1:0] op,
                                             input logic [IN_W-1:0] an_r,
                                             input logic [IN_W-1:0] ad_r,
                                             input logic [IN_W-1:0] bn_r,
                                             input logic [IN_W-1:0] bd_r);
    longint an, ad, bn, bd, n, d, x, y, t;
    rat_res_t r;
    an = longint'($signed(an_r));
    ad = longint'($signed(ad_r));
    bn = longint'($signed(bn_r));
    bd = longint'($signed(bd_r));
    n = 0;
    d = 0;
    r = '0;
    case (op)
      OP_ADD: begin
        n = an * bd + bn * ad;
        d = ad * bd;
      end
      OP_MUL: begin
        n = an * bn;
        d = ad * bd;
      end
      OP_INC: begin
        n = an + ad;
        d = ad;
      end
      default: r.eq = (an == bn) && (ad == bd);
    endcase
    if (op != OP_CMP) begin
      // wrap to 32 bits, then reduce only when both parts are positive
      n = longint'($signed(n[31:0]));
      d = longint'($signed(d[31:0]));
      if ((n < d ? n : d) >= 1) begin
        x = n;
        y = d;
        while (y != 0) begin
          t = x % y;
          x = y;
          y = t;
        end
        n = n / x;
        d = d / x;
      end
      r.num = n[31:0];
      r.den = d[31:0];
    end
    return r;
  endfunction

  // Pick a field value: full range, small positives and negatives, zero and extremes
  function automatic logic [IN_W-1:0] rand_field();
    logic [IN_W-1:0] v;
    case ($urandom_range(9))
      0: v = '0;
      1: begin
        case ($urandom_range(3))
          0: v = 16'h7FFF;
          1: v = 16'h8000;
          2: v = 16'h8001;
          default: v = 16'hFFFF;
        endcase
      end
      2, 3, 4: v = 16'($urandom_range(1, 48));
      5: v = 16'd0 - 16'($urandom_range(1, 48));
      default: v = 16'($urandom());
    endcase
    return v;
  endfunction

  // Offer one item after random gaps; hold it until accepted
  task automatic send_ratio_item(input logic [1:0] op,
                                 input logic [IN_W-1:0] an,
                                 input logic [IN_W-1:0] ad,
                                 input logic [IN_W-1:0] bn,
                                 input logic [IN_W-1:0] bd,
                                 input rat_res_t want);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {bd, bn, ad, an};
    do @(posedge clk); while (!in_tready);
    ratio_q.push_back(want);
  endtask

  // Result receiver: random stalls, plus one long hold-off on request
  initial begin : sink
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (stall_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        stall_req = 0;
      end else begin
        out_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    rat_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (ratio_q.size() == 0) begin
        $display("%0t: unexpected result num=%h den=%h eq=%b", $time,
                 out_tdata[RES_W-1:0], out_tdata[2*RES_W-1:RES_W], out_tuser);
        mismatch_cnt++;
      end else begin
        want = ratio_q.pop_front();
        if (out_tdata[RES_W-1:0] !== want.num) begin
          $display("%0t: res_num expected %h actual %h", $time, want.num,
                   out_tdata[RES_W-1:0]);
          mismatch_cnt++;
        end
        if (out_tdata[2*RES_W-1:RES_W] !== want.den) begin
          $display("%0t: res_den expected %h actual %h", $time, want.den,
                   out_tdata[2*RES_W-1:RES_W]);
          mismatch_cnt++;
        end
        if (out_tuser !== want.eq) begin
          $display("%0t: equal expected %b actual %b", $time, want.eq, out_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Reset, directed rows, then three random phases with different idling
  initial begin : stim
    dir_row_t row;
    rat_res_t want;
    logic [1:0] op;
    logic [IN_W-1:0] an, ad, bn, bd;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= '0;
    rst_n     <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < N_DIR; i++) begin
      row = dir_rows[i];
      if (row.has_want) want = '{row.w_num, row.w_den, row.w_eq};
      else want = predict_ratio(row.op, row.an, row.ad, row.bn, row.bd);
      send_ratio_item(row.op, row.an, row.ad, row.bn, row.bd, want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      // pause the sender until every result is back
      in_tvalid <= 1'b0;
      @(posedge clk);
      while (ratio_q.size() != 0) @(posedge clk);
      src_idle_pct = (phase == 0) ? 20 : (phase == 1) ? 59 : 0;
      snk_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 20 : 0;
      // long receiver hold-off while the sender keeps offering
      if (phase == 2) stall_req = 1;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        op = 2'($urandom_range(3));
        an = rand_field();
        ad = rand_field();
        bn = rand_field();
        bd = rand_field();
        if (op == OP_CMP) begin
          case ($urandom_range(3))
            0: begin
              bn = an;
              bd = ad;
            end
            1: bn = an;
            2: bd = ad;
            default: ;
          endcase
        end
        send_ratio_item(op, an, ad, bn, bd, predict_ratio(op, an, ad, bn, bd));
      end
    end

    // drain, then let the pipeline settle
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (ratio_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
    if (ratio_q.size() != 0) mismatch_cnt++;
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
